@@ hdl/aar_pkg.sv @@
package aar_pkg;

    localparam int unsigned NumChainsDefault = 64;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam logic [31:0] BaseTempReset = 32'd65536;
    localparam logic [31:0] GainReset = 32'd65536;
    localparam logic [15:0] TolReset = 16'd1;

    localparam logic [1:0] RegBaseTemp = 2'd0;
    localparam logic [1:0] RegGain = 2'd1;
    localparam logic [1:0] RegTol = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [5:0]  chain;
        logic [31:0] cost;
        logic [15:0] uniform_sample;
        logic [15:0] start_count;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        new_best;
        logic [31:0] best_cost;
        logic [5:0]  best_chain;
        logic [31:0] chain_temperature;
        logic [15:0] worse_count;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LN_MUL,
        ST_GAIN_MUL,
        ST_TEMP,
        ST_DIV,
        ST_SLOG_NORM,
        ST_SLOG_SQ,
        ST_LIM_MUL,
        ST_DECIDE,
        ST_DONE
    } t_state;

endpackage

@@ hdl/annealing_acceptance_reheat_top.sv @@
// A proposal that needs the exponential test runs two 16-step log loops and a 48-step
// restoring divider on one shared datapath; a proposal settled without that test skips
// the divider and the second log loop, and a load skips the whole evaluation.
// Throughput: one item at a time; busy falls as the result strobe rises, so the next
// item can be accepted at the edge that takes the result. The receiver cannot stall.
// Reset (synchronous, active low) restores the state, the config registers, the best cost and chain, and the strobe.
module annealing_acceptance_reheat_top #(
    parameter int unsigned NUM_CHAINS = aar_pkg::NumChainsDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  aar_pkg::t_in_item i_item,
    output logic              o_valid,
    output aar_pkg::t_out_item o_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int unsigned AW = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;

    aar_pkg::t_state r_state, n_state;
    aar_pkg::t_in_item r_in;
    logic [31:0] r_t0, r_gain;
    logic [15:0] r_tol;
    logic [31:0] r_best_cost;
    logic [5:0]  r_best_chain;
    logic [31:0] mem_cost [NUM_CHAINS];
    logic [15:0] mem_cnt [NUM_CHAINS];
    logic [31:0] r_rd_cost;
    logic [15:0] r_rd_cnt;

    logic [32:0] r_diff;
    logic [15:0] r_cnt;
    logic [63:0] r_m;
    logic [4:0]  r_e;
    logic [15:0] r_frac;
    logic [5:0]  r_step;
    logic [63:0] r_acc;
    logic [31:0] r_temp;
    logic [47:0] r_quo;
    logic [32:0] r_rem;
    logic        r_accept;
    logic        r_nb;
    logic        r_valid;
    aar_pkg::t_out_item r_out;

    logic        in_range;
    logic [AW-1:0] addr;
    logic [31:0] log_in;
    logic [4:0]  msb;
    logic [63:0] sq;
    logic [32:0] rem_sh;
    logic [31:0] cost_after;
    logic [15:0] cnt_upd;
    logic [63:0] temp_sum;
    logic [31:0] temp_calc;
    logic        dec_accept;

    assign in_range = ({26'd0, r_in.chain} < 32'(NUM_CHAINS));
    assign addr = r_in.chain[AW-1:0];
    assign busy = (r_state != aar_pkg::ST_IDLE);
    assign o_cfg_ready = !busy && !start;
    assign o_valid = r_valid;
    assign o_item = r_out;

    always_comb begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (log_in[i]) begin
                msb = 5'(i);
            end
        end
    end

    always_comb begin
        cnt_upd = r_cnt;
        if (r_diff[32]) begin
            cnt_upd = 16'd0;
        end else if (r_diff > {17'd0, r_tol} && r_cnt != 16'hFFFF) begin
            cnt_upd = r_cnt + 16'd1;
        end
    end

    assign log_in = (r_state == aar_pkg::ST_LOG_NORM) ? {16'd0, cnt_upd} + 32'd1
                                                     : {16'd0, r_in.uniform_sample};
    assign sq = r_m[31:0] * r_m[31:0];
    assign rem_sh = {r_rem[31:0], r_quo[47]};
    assign temp_sum = {16'd0, r_acc[63:16]} + {32'd0, r_t0};
    assign temp_calc = (temp_sum[63:32] != 32'd0) ? 32'hFFFF_FFFF : temp_sum[31:0];

    always_comb begin
        if (r_diff[32] || r_diff == 33'd0) begin
            dec_accept = 1'b1;
        end else if (r_temp == 32'd0) begin
            dec_accept = 1'b0;
        end else if (r_in.uniform_sample == 16'd0) begin
            dec_accept = 1'b1;
        end else begin
            dec_accept = ({16'd0, r_quo} < {32'd0, r_acc[63:32]});
        end
    end

    assign cost_after = dec_accept ? r_in.cost : r_rd_cost;

    always_comb begin
        n_state = r_state;
        case (r_state)
            aar_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = aar_pkg::ST_READ;
                end
            end
            aar_pkg::ST_READ: begin
                if (!in_range || !r_in.kind) begin
                    n_state = aar_pkg::ST_DONE;
                end else begin
                    n_state = aar_pkg::ST_EVAL;
                end
            end
            aar_pkg::ST_EVAL: n_state = aar_pkg::ST_LOG_NORM;
            aar_pkg::ST_LOG_NORM: n_state = aar_pkg::ST_LOG_SQ;
            aar_pkg::ST_LOG_SQ: begin
                if (r_step == 6'd15) begin
                    n_state = aar_pkg::ST_LN_MUL;
                end
            end
            aar_pkg::ST_LN_MUL: n_state = aar_pkg::ST_GAIN_MUL;
            aar_pkg::ST_GAIN_MUL: n_state = aar_pkg::ST_TEMP;
            aar_pkg::ST_TEMP: begin
                if (r_diff[32] || r_diff == 33'd0 || temp_calc == 32'd0
                        || r_in.uniform_sample == 16'd0) begin
                    n_state = aar_pkg::ST_DECIDE;
                end else begin
                    n_state = aar_pkg::ST_DIV;
                end
            end
            aar_pkg::ST_DIV: begin
                if (r_step == 6'd47) begin
                    n_state = aar_pkg::ST_SLOG_NORM;
                end
            end
            aar_pkg::ST_SLOG_NORM: n_state = aar_pkg::ST_SLOG_SQ;
            aar_pkg::ST_SLOG_SQ: begin
                if (r_step == 6'd15) begin
                    n_state = aar_pkg::ST_LIM_MUL;
                end
            end
            aar_pkg::ST_LIM_MUL: n_state = aar_pkg::ST_DECIDE;
            aar_pkg::ST_DECIDE: n_state = aar_pkg::ST_DONE;
            aar_pkg::ST_DONE: n_state = aar_pkg::ST_IDLE;
            default: n_state = aar_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aar_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0 <= aar_pkg::BaseTempReset;
            r_gain <= aar_pkg::GainReset;
            r_tol <= aar_pkg::TolReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                aar_pkg::RegBaseTemp: r_t0 <= i_cfg_data;
                aar_pkg::RegGain: r_gain <= i_cfg_data;
                aar_pkg::RegTol: r_tol <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aar_pkg::ST_IDLE && start) begin
            r_in <= i_item;
        end
        if (r_state == aar_pkg::ST_READ) begin
            r_rd_cost <= mem_cost[addr];
            r_rd_cnt <= mem_cnt[addr];
        end
        if (r_state == aar_pkg::ST_READ && in_range && !r_in.kind) begin
            mem_cost[addr] <= r_in.cost;
            mem_cnt[addr] <= r_in.start_count;
        end
        if (r_state == aar_pkg::ST_DECIDE) begin
            mem_cnt[addr] <= r_cnt;
            if (dec_accept) begin
                mem_cost[addr] <= r_in.cost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            aar_pkg::ST_EVAL: begin
                r_diff <= {1'b0, r_in.cost} - {1'b0, r_rd_cost};
                r_cnt <= r_rd_cnt;
            end
            aar_pkg::ST_LOG_NORM, aar_pkg::ST_SLOG_NORM: begin
                if (r_state == aar_pkg::ST_LOG_NORM) begin
                    r_cnt <= cnt_upd;
                end
                r_e <= msb;
                r_m <= {32'd0, log_in << (5'd31 - msb)};
                r_frac <= 16'd0;
                r_step <= 6'd0;
            end
            aar_pkg::ST_LOG_SQ, aar_pkg::ST_SLOG_SQ: begin
                r_step <= r_step + 6'd1;
                if (sq[63]) begin
                    r_m <= {32'd0, sq[63:32]};
                    r_frac[4'(5'd15 - r_step[4:0])] <= 1'b1;
                end else begin
                    r_m <= {32'd0, sq[62:31]};
                end
            end
            aar_pkg::ST_LN_MUL: begin
                r_acc <= {27'd0, r_e, r_frac} * {32'd0, aar_pkg::Ln2Q32};
            end
            aar_pkg::ST_GAIN_MUL: begin
                r_acc <= {32'd0, r_gain} * {32'd0, r_acc[63:32]};
            end
            aar_pkg::ST_TEMP: begin
                r_temp <= temp_calc;
                r_quo <= {r_diff[31:0], 16'd0};
                r_rem <= 33'd0;
                r_step <= 6'd0;
            end
            aar_pkg::ST_DIV: begin
                r_step <= r_step + 6'd1;
                if (rem_sh >= {1'b0, r_temp}) begin
                    r_rem <= rem_sh - {1'b0, r_temp};
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[46:0], 1'b0};
                end
            end
            aar_pkg::ST_LIM_MUL: begin
                r_acc <= {32'd0, 32'h0010_0000 - {11'd0, r_e, r_frac}}
                         * {32'd0, aar_pkg::Ln2Q32};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aar_pkg::ST_TEMP) begin
            r_accept <= 1'b0;
        end else if (r_state == aar_pkg::ST_DECIDE && r_in.kind) begin
            r_accept <= dec_accept;
        end else if (r_state == aar_pkg::ST_READ) begin
            r_accept <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_cost <= '1;
            r_best_chain <= 6'd0;
            r_nb <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (r_state == aar_pkg::ST_READ) begin
                r_nb <= 1'b0;
                if (in_range && !r_in.kind && r_in.chain == 6'd0) begin
                    r_best_cost <= r_in.cost;
                    r_best_chain <= 6'd0;
                end
            end
            if (r_state == aar_pkg::ST_DECIDE && cost_after < r_best_cost) begin
                r_best_cost <= cost_after;
                r_best_chain <= r_in.chain;
                r_nb <= 1'b1;
            end
            if (r_state == aar_pkg::ST_DONE) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aar_pkg::ST_DONE) begin
            r_out.best_cost <= r_best_cost;
            r_out.best_chain <= r_best_chain;
            if (!in_range) begin
                r_out.accepted <= 1'b0;
                r_out.new_best <= 1'b0;
                r_out.chain_temperature <= 32'd0;
                r_out.worse_count <= 16'd0;
            end else if (!r_in.kind) begin
                r_out.accepted <= 1'b0;
                r_out.new_best <= 1'b0;
                r_out.chain_temperature <= 32'd0;
                r_out.worse_count <= r_in.start_count;
            end else begin
                r_out.accepted <= r_accept;
                r_out.new_best <= r_nb;
                r_out.chain_temperature <= r_temp;
                r_out.worse_count <= r_cnt;
            end
        end
    end

`ifndef SYNTH
    a_valid_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aar_pkg::ST_DONE) |=> o_valid) else $error("missing result strobe");
    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("config ready while busy");
    a_best_only_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aar_pkg::ST_DECIDE) |=> (r_best_cost <= $past(r_best_cost)))
        else $error("best cost rose on proposal");
`endif

endmodule
